// ----- hw/rtl/tvp_pkg.sv -----
// Shared types, constants and latencies for the vertex projection block.
package tvp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W = 32;
  localparam int PIX_W = 16;
  localparam int H_W = 64;
  localparam int PROD_W = 80;
  localparam int CFG_IDX_W = 1;
  localparam int IN_DATA_W = 328;
  localparam int OUT_DATA_W = 64;

  // Pixel scaler: two partial-product stages, one saturation stage, one stage per bit.
  localparam int SCALE_LAT = 3 + PIX_W;
  // Lane: products, row sums, sign normalization, then the scalers.
  localparam int LANE_LAT = 3 + SCALE_LAT;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_XFORM = 1'b1;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [15:0][WORD_W-1:0] matrix_t;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic wz;
  } pix_t;

endpackage

// ----- hw/rtl/tvp_scale.sv -----
// Pipelined saturating scaler: floor(size * num / den) clipped to 0..65535.
module tvp_scale (
  input  logic                      clk,
  input  logic                      en,
  input  logic [tvp_pkg::PIX_W-1:0] size,
  input  logic [tvp_pkg::H_W-1:0]   num,
  input  logic [tvp_pkg::H_W-1:0]   den,
  input  logic                      zf,
  output logic [tvp_pkg::PIX_W-1:0] pix
);
  import tvp_pkg::*;

  logic [PIX_W+31:0] pl, ph;
  logic [H_W-1:0] da, db;
  logic za, zb;
  logic [PROD_W-1:0] pb;

  logic [PROD_W-1:0] rem_s [0:PIX_W];
  logic [PIX_W-1:0]  q_s   [0:PIX_W];
  logic [H_W-1:0]    d_s   [0:PIX_W];
  logic              z_s   [0:PIX_W];
  logic              sat_s [0:PIX_W];

  // Split the 16 x 64 product into two 16 x 32 halves, then sum them and flag saturation.
  always_ff @(posedge clk) begin
    if (en) begin
      pl <= size * num[31:0];
      ph <= size * num[63:32];
      da <= den;
      za <= zf;
      pb <= (PROD_W'(ph) << 32) + PROD_W'(pl);
      db <= da;
      zb <= za;
      sat_s[0] <= pb >= (PROD_W'(db) << PIX_W);
      rem_s[0] <= pb;
      q_s[0] <= '0;
      d_s[0] <= db;
      z_s[0] <= zb;
    end
  end

  // One restoring quotient bit per stage, most significant first.
  for (genvar j = 0; j < PIX_W; j++) begin : g_div
    localparam int B = PIX_W - 1 - j;
    logic [PROD_W-1:0] dsh;
    assign dsh = PROD_W'(d_s[j]) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_s[j] >= dsh) begin
          rem_s[j+1] <= rem_s[j] - dsh;
          q_s[j+1] <= q_s[j] | (PIX_W'(1) << B);
        end else begin
          rem_s[j+1] <= rem_s[j];
          q_s[j+1] <= q_s[j];
        end
        d_s[j+1] <= d_s[j];
        z_s[j+1] <= z_s[j];
        sat_s[j+1] <= sat_s[j];
      end
    end
  end

  assign pix = z_s[PIX_W] ? '0 : (sat_s[PIX_W] ? '1 : q_s[PIX_W]);

endmodule

// ----- hw/rtl/tvp_lane.sv -----
// One vertex lane: matrix product, perspective normalization and pixel mapping.
module tvp_lane #(
  parameter int FRAC_BITS = tvp_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      en,
  input  tvp_pkg::matrix_t          mtx,
  input  tvp_pkg::word_t            vx,
  input  tvp_pkg::word_t            vy,
  input  tvp_pkg::word_t            vz,
  input  logic [tvp_pkg::PIX_W-1:0] screen_width,
  input  logic [tvp_pkg::PIX_W-1:0] screen_height,
  output tvp_pkg::pix_t             pix
);
  import tvp_pkg::*;

  logic signed [H_W-1:0] prod [0:3][0:2];
  logic signed [H_W-1:0] offs [0:3];
  logic signed [H_W-1:0] h    [0:3];
  logic signed [H_W-1:0] nx, ny, dd, hsum, hdif, hw2;
  logic [H_W-1:0] num_x, num_y, den;
  logic zf_x, zf_y;
  logic wz_d [0:SCALE_LAT];
  word_t vin [0:2];

  assign vin[0] = vx;
  assign vin[1] = vy;
  assign vin[2] = vz;

  // Products are floored by the arithmetic shift.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= (H_W'($signed(mtx[r*4+c])) * H_W'(vin[c])) >>> FRAC_BITS;
        end
        offs[r] <= H_W'($signed(mtx[r*4+3]));
      end
      for (int r = 0; r < 4; r++) begin
        h[r] <= prod[r][0] + prod[r][1] + prod[r][2] + offs[r];
      end
    end
  end

  always_comb begin
    hsum = h[3] + h[0];
    hdif = h[3] - h[1];
    hw2 = h[3] <<< 1;
    if (h[3][H_W-1]) begin
      nx = -hsum;
      ny = -hdif;
      dd = -hw2;
    end else begin
      nx = hsum;
      ny = hdif;
      dd = hw2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_x <= nx;
      num_y <= ny;
      den <= dd;
      zf_x <= (h[3] == '0) || nx[H_W-1];
      zf_y <= (h[3] == '0) || ny[H_W-1];
      wz_d[0] <= (h[3] == '0);
      for (int k = 0; k < SCALE_LAT; k++) begin
        wz_d[k+1] <= wz_d[k];
      end
    end
  end

  tvp_scale u_scale_x (
    .clk  (clk),
    .en   (en),
    .size (screen_width),
    .num  (num_x),
    .den  (den),
    .zf   (zf_x),
    .pix  (pix.x)
  );

  tvp_scale u_scale_y (
    .clk  (clk),
    .en   (en),
    .size (screen_height),
    .num  (num_y),
    .den  (den),
    .zf   (zf_y),
    .pix  (pix.y)
  );

  assign pix.wz = wz_d[SCALE_LAT];

endmodule

// ----- hw/rtl/tvp_merge.sv -----
// Edge merge stage: holds one projected triangle and sends its edges v0-v1, v1-v2 and v2-v0 in turn.
module tvp_merge (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tvp_pkg::pix_t                  v0,
  input  tvp_pkg::pix_t                  v1,
  input  tvp_pkg::pix_t                  v2,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tvp_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tuser,
  output logic                           m_tlast
);
  import tvp_pkg::*;

  pix_t vb [0:2];
  logic full, full_next;
  logic [1:0] cnt, cnt_next;
  pix_t ps, pe;
  logic take, done;

  assign done = full && m_tready && (cnt == 2'd2);
  assign in_ready = !full || done;
  assign take = in_valid && in_ready;

  always_comb begin
    full_next = full;
    cnt_next = cnt;
    if (full && m_tready) begin
      cnt_next = (cnt == 2'd2) ? 2'd0 : cnt + 2'd1;
      if (cnt == 2'd2) full_next = 1'b0;
    end
    if (take) begin
      full_next = 1'b1;
      cnt_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      cnt <= 2'd0;
    end else begin
      full <= full_next;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      vb[0] <= v0;
      vb[1] <= v1;
      vb[2] <= v2;
    end
  end

  always_comb begin
    case (cnt)
      2'd0: begin
        ps = vb[0];
        pe = vb[1];
      end
      2'd1: begin
        ps = vb[1];
        pe = vb[2];
      end
      default: begin
        ps = vb[2];
        pe = vb[0];
      end
    endcase
  end

  assign m_tvalid = full;
  assign m_tdata = {pe.y, pe.x, ps.y, ps.x};
  assign m_tuser = ps.wz || pe.wz;
  assign m_tlast = (cnt == 2'd2);

`ifndef SYNTHESIS
  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast && !in_valid) |=> !m_tvalid)
    else $error("merge stage still full after last edge");
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |-> (full && cnt != 2'd2 || full && !m_tready))
    else $error("merge stage refused a triangle while able to take it");
  a_new_starts: assert property (@(posedge clk) disable iff (rst)
    take |=> (cnt == 2'd0 && full))
    else $error("new triangle did not start at its first edge");
`endif

endmodule

// ----- hw/rtl/triangle_vertex_project_to_screen.sv -----
// Top level of the triangle vertex projection block.
//
// Input stream s_*: s_tuser selects the request kind. A load request writes one
// matrix word at entry_index; a transform request carries three vertices in
// signed fixed point. Each transform yields the edge requests on m_*:
// v0-v1, v1-v2, v2-v0, the last marked by m_tlast, w_zero on m_tuser.
// Three lanes, one per vertex, project in parallel; each lane is a fully
// pipelined matrix product followed by a one-bit-per-stage pixel divider.
// The pipeline takes one request per cycle while s_tready is high, and the
// output sends one edge per cycle while m_tready is high, so the output
// channel limits the triangle rate. A load writes the matrix and yields no edge.
// When m_tready is low the merge stage holds its triangle; once the pipeline
// head is full it stops and s_tready drops until the edges drain.
// Reset empties the pipeline, sets the matrix to identity and the screen to
// 640 by 480. The cfg port writes screen width (index 0) or height (index 1)
// while the block is idle: a rule the user must keep, as the block does not enforce it.
module triangle_vertex_project_to_screen #(
  parameter int FRAC_BITS = tvp_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tvp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tvp_pkg::PIX_W-1:0]     cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // entry_index, entry_value, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
  input  logic [tvp_pkg::IN_DATA_W-1:0] s_tdata,
  // action
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // start_x, start_y, end_x, end_y
  output logic [tvp_pkg::OUT_DATA_W-1:0] m_tdata,
  // w_zero
  output logic                          m_tuser,
  output logic                          m_tlast
);
  import tvp_pkg::*;

  matrix_t mtx;
  logic [PIX_W-1:0] screen_width, screen_height;
  logic [LANE_LAT-1:0] vld;
  logic en, acc, mrg_ready;
  pix_t lp [0:2];
  logic [3:0] entry_index;
  word_t entry_value;

  assign entry_index = s_tdata[3:0];
  assign entry_value = s_tdata[35:4];
  assign en = !vld[LANE_LAT-1] || mrg_ready;
  assign s_tready = en;
  assign acc = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= 16'd640;
      screen_height <= 16'd480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width <= cfg_wdata;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mtx[i] <= (i % 5 == 0) ? (WORD_W'(1) << FRAC_BITS) : '0;
      end
    end else if (acc && s_tuser == ACT_LOAD) begin
      mtx[entry_index] <= entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LANE_LAT-2:0], acc && s_tuser == ACT_XFORM};
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    tvp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk           (clk),
      .en            (en),
      .mtx           (mtx),
      .vx            (s_tdata[36 + 96*k +: 32]),
      .vy            (s_tdata[68 + 96*k +: 32]),
      .vz            (s_tdata[100 + 96*k +: 32]),
      .screen_width  (screen_width),
      .screen_height (screen_height),
      .pix           (lp[k])
    );
  end

  tvp_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[LANE_LAT-1]),
    .in_ready (mrg_ready),
    .v0       (lp[0]),
    .v1       (lp[1]),
    .v2       (lp[2]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTHESIS
  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    (vld[LANE_LAT-1] && !en) |=> vld[LANE_LAT-1])
    else $error("pipeline head lost a triangle while stalled");
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (vld[LANE_LAT-1] && !mrg_ready) |-> !s_tready)
    else $error("request accepted while the pipeline was stalled");
  a_load_no_slot: assert property (@(posedge clk) disable iff (rst)
    (acc && s_tuser == ACT_LOAD) |=> !vld[0])
    else $error("load request took a pipeline slot");
`endif

endmodule
